// ===== design/rlhs_pkg.sv =====
// shared types, constants and codes of the line hypothesis scorer
package rlhs_pkg;

	localparam int DefMaxPoints = 1024;

	localparam logic [15:0] ThreshReset = 16'd1000;
	localparam logic [10:0] MinInlReset = 11'd35;
	localparam logic [15:0] RangeReset  = 16'd5000;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_EVAL  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_STORED   = 3'd0,
		ST_FILTERED = 3'd1,
		ST_FULL     = 3'd2,
		ST_DEGEN    = 3'd3,
		ST_TOO_FEW  = 3'd4,
		ST_ACCEPTED = 3'd5,
		ST_NEW_BEST = 3'd6,
		ST_CLEARED  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		REG_THRESH = 2'd0,
		REG_MIN    = 2'd1,
		REG_RANGE  = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_A,
		S_RD_B,
		S_CHECK,
		S_SCAN,
		S_DRAIN,
		S_DONE,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic [15:0]        range_mm;
		logic [9:0]         first_index;
		logic [9:0]         second_index;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [10:0]        stored_points;
		logic [10:0]        inlier_count;
		logic [10:0]        best_count;
		logic signed [15:0] best_first_x;
		logic signed [15:0] best_first_y;
		logic signed [15:0] best_second_x;
		logic signed [15:0] best_second_y;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic take_in;    // capture input word
		logic do_load;    // store or filter a point
		logic do_clear;
		logic rd_a;       // read first pair point
		logic rd_b;       // read second pair point
		logic do_check;   // degenerate test, set up line
		logic scan_start;
		logic do_scan;    // issue one point read
		logic do_decide;
		logic do_degen;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic     idx_bad;
		logic     pair_bad;
		logic     scan_last;  // last read issued
		logic     pipe_empty;
		op_t      op;
	} stat_t;

endpackage

// ===== design/rlhs_ctrl.sv =====
// controller state machine of the line hypothesis scorer
module rlhs_ctrl import rlhs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				case (st.op)
					OP_LOAD: begin
						cmd.do_load = 1'b1;
						state_d = S_OUT;
					end
					OP_CLEAR: begin
						cmd.do_clear = 1'b1;
						state_d = S_OUT;
					end
					OP_EVAL: begin
						if (st.idx_bad) begin
							cmd.do_degen = 1'b1;
							state_d = S_OUT;
						end else begin
							cmd.rd_a = 1'b1;
							state_d = S_RD_A;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_RD_A: begin
				cmd.rd_b = 1'b1;
				state_d = S_RD_B;
			end
			S_RD_B: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.do_check = 1'b1;
				if (st.pair_bad) begin
					cmd.do_degen = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.do_scan = 1'b1;
				if (st.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (st.pipe_empty) begin
					cmd.do_decide = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== design/rlhs_datapath.sv =====
// point memory, line setup, residual pipeline and best-line registers
module rlhs_datapath import rlhs_pkg::*; #(
	parameter int MAX_POINTS = DefMaxPoints
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  in_word_t    in_word,
	input  logic [15:0] thresh,
	input  logic [10:0] min_inl,
	input  logic [15:0] max_range,
	output stat_t       st,
	output out_word_t   out_word
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int IW = (CW > 10) ? CW : 10;

	in_word_t in_q;
	logic [31:0] mem [MAX_POINTS];
	logic [31:0] rd_s1;
	logic [CW-1:0] total_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] best_q;
	logic          best_pres_q;
	logic [63:0]   best_ep_q;
	logic [2:0]    status_q;

	logic signed [15:0] xa_q, ya_q, xb_q, yb_q;
	logic signed [16:0] dx_q, dy_q;
	logic [32:0]        lim_q;

	logic [CW-1:0] scan_q;
	logic          v_s1, v_s2, v_s3;
	logic signed [33:0] p1_s2, p2_s2;
	logic signed [34:0] num_s3;

	logic [AW-1:0] rd_addr;
	logic idx_bad;
	logic signed [16:0] dx_w, dy_w;

	// first and second index, sized to hold both an index and the point count
	logic [IW-1:0] ia, ib;
	assign ia = IW'(in_q.first_index);
	assign ib = IW'(in_q.second_index);
	assign idx_bad = (in_q.first_index == in_q.second_index) ||
		(ia >= IW'(total_q)) || (ib >= IW'(total_q));

	always_comb begin
		if (cmd.rd_a) begin
			rd_addr = AW'(in_q.first_index);
		end else if (cmd.rd_b) begin
			rd_addr = AW'(in_q.second_index);
		end else begin
			rd_addr = scan_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		rd_s1 <= mem[rd_addr];
		if (cmd.do_load && (in_q.range_mm < max_range) && (total_q < CW'(MAX_POINTS))) begin
			mem[total_q[AW-1:0]] <= {in_q.point_x, in_q.point_y};
		end
	end

	// pair latching: read of a lands in S_RD_A, b in S_RD_B
	logic rd_a_d, rd_b_d;
	always_ff @(posedge clk) begin
		rd_a_d <= cmd.rd_a;
		rd_b_d <= cmd.rd_b;
		if (cmd.take_in) begin
			in_q <= in_word;
		end
		if (rd_a_d) begin
			xa_q <= rd_s1[31:16];
			ya_q <= rd_s1[15:0];
		end
		if (rd_b_d) begin
			xb_q <= rd_s1[31:16];
			yb_q <= rd_s1[15:0];
		end
	end

	assign dx_w = 17'(xb_q) - 17'(xa_q);
	assign dy_w = 17'(yb_q) - 17'(ya_q);

	always_ff @(posedge clk) begin
		if (cmd.do_check) begin
			dx_q  <= dx_w;
			dy_q  <= dy_w;
			lim_q <= 33'(thresh) * 33'(dx_w < 0 ? -dx_w : dx_w);
		end
	end

	// residual pipeline: read, products, difference, compare
	always_ff @(posedge clk) begin
		p1_s2  <= (34'(signed'(rd_s1[15:0])) - 34'(ya_q)) * 34'(dx_q);
		p2_s2  <= 34'(dy_q) * (34'(signed'(rd_s1[31:16])) - 34'(xa_q));
		num_s3 <= 35'(p1_s2) - 35'(p2_s2);
	end

	logic [34:0] anum;
	assign anum = num_s3 < 0 ? 35'(-num_s3) : 35'(num_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			scan_q <= '0;
		end else begin
			v_s1 <= cmd.do_scan;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.scan_start) begin
				scan_q <= '0;
			end else if (cmd.do_scan) begin
				scan_q <= scan_q + 1'b1;
			end
		end
	end

	assign st.idx_bad    = idx_bad;
	assign st.pair_bad   = (xa_q == 0) || (ya_q == 0) || (xb_q == 0) || (yb_q == 0) ||
		(xa_q == xb_q);
	assign st.scan_last  = (scan_q + 1'b1 >= total_q);
	assign st.pipe_empty = !v_s1 && !v_s2 && !v_s3;
	assign st.op         = op_t'(in_q.op);

	logic [CW:0] min_p1;
	assign min_p1 = (CW+1)'(min_inl) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			count_q     <= '0;
			best_q      <= '0;
			best_pres_q <= 1'b0;
			best_ep_q   <= '0;
			status_q    <= ST_STORED;
		end else begin
			if (cmd.scan_start) begin
				count_q <= '0;
			end else if (v_s3 && anum != 0 && anum < 35'(lim_q)) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.do_load) begin
				count_q <= '0;
				if (in_q.range_mm >= max_range) begin
					status_q <= ST_FILTERED;
				end else if (total_q >= CW'(MAX_POINTS)) begin
					status_q <= ST_FULL;
				end else begin
					total_q  <= total_q + 1'b1;
					status_q <= ST_STORED;
				end
			end
			if (cmd.do_clear) begin
				total_q     <= '0;
				count_q     <= '0;
				best_q      <= '0;
				best_pres_q <= 1'b0;
				best_ep_q   <= '0;
				status_q    <= ST_CLEARED;
			end
			if (cmd.do_degen) begin
				count_q  <= '0;
				status_q <= ST_DEGEN;
			end
			if (cmd.do_decide) begin
				if ((CW+1)'(count_q) <= min_p1) begin
					status_q <= ST_TOO_FEW;
				end else if (!best_pres_q || count_q > best_q) begin
					best_pres_q <= 1'b1;
					best_q      <= count_q;
					best_ep_q   <= {xa_q, ya_q, xb_q, yb_q};
					status_q    <= ST_NEW_BEST;
				end else begin
					status_q <= ST_ACCEPTED;
				end
			end
		end
	end

	assign out_word.status        = status_q;
	assign out_word.stored_points = 11'(total_q);
	assign out_word.inlier_count  = 11'(count_q);
	assign out_word.best_count    = 11'(best_q);
	assign out_word.best_first_x  = best_ep_q[63:48];
	assign out_word.best_first_y  = best_ep_q[47:32];
	assign out_word.best_second_x = best_ep_q[31:16];
	assign out_word.best_second_y = best_ep_q[15:0];

endmodule

// ===== design/ransac_line_hypothesis_scorer_core.sv =====
// RANSAC line hypothesis scorer: top level with config registers
// Usage:
//  in channel (in_valid/in_ready/in_data): one word per op; load, evaluate, clear.
//  op 3 words are taken and dropped with no result.
//  out channel (out_valid/out_ready/out_data): one result word per load,
//  evaluate or clear word, in order.
//  cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//  always ready; write only while the block is idle.
// A load, clear or degenerate index pair goes straight from the check to its result;
//  other degenerate pairs are found once both pair points are read.
//  A scored pair then has the residual pipeline walk
//  the point memory one entry per cycle on its single read port.
// One word is worked on at a time; the next is taken once the result leaves.
// A stalled receiver holds the result and the block waits.
// Reset clears the point count, best line and registers to defaults;
//  the point memory is not cleared.
module ransac_line_hypothesis_scorer_core import rlhs_pkg::*; #(
	parameter int MAX_POINTS = DefMaxPoints
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] thresh_q, range_q;
	logic [10:0] min_q;
	cmd_t  cmd;
	stat_t st;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= ThreshReset;
			min_q    <= MinInlReset;
			range_q  <= RangeReset;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_THRESH: thresh_q <= cfg_data;
				REG_MIN:    min_q    <= cfg_data[10:0];
				REG_RANGE:  range_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	rlhs_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .st, .cmd
	);

	rlhs_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk, .arst_n, .cmd, .in_word(in_data), .thresh(thresh_q), .min_inl(min_q),
		.max_range(range_q), .st, .out_word(out_data)
	);

`ifndef NO_ASSERTIONS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input and output open together");
	a_take_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("second word taken early");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.inlier_count <= out_data.stored_points))
		else $error("inlier count above stored points");
`endif

endmodule
